@@ rtl/core/srhp_pkg.sv @@
package srhp_pkg;

	localparam int HEADER_BYTES = 100;
	localparam int POS_W        = 7;
	localparam int MAJOR_W      = 10;

	localparam int MAGIC_LEN     = 9;
	localparam int VERSION_LEN   = 12;
	localparam int CHALLENGE_LEN = 16;
	localparam int AUTH_POS      = MAGIC_LEN + VERSION_LEN;
	localparam int DIMS_PLAIN    = AUTH_POS + 4;
	localparam int DIMS_AUTH     = DIMS_PLAIN + CHALLENGE_LEN + 4;

	localparam logic [POS_W-1:0] MAGIC_END   = POS_W'(MAGIC_LEN);
	localparam logic [POS_W-1:0] AUTH_START  = POS_W'(AUTH_POS);
	localparam logic [POS_W-1:0] AUTH_LAST   = POS_W'(DIMS_PLAIN - 1);
	localparam logic [POS_W-1:0] DIMS_START  = POS_W'(DIMS_PLAIN);
	localparam logic [POS_W-1:0] DIMS_SKIP   = POS_W'(DIMS_AUTH);
	localparam logic [POS_W-1:0] HEADER_LAST = POS_W'(HEADER_BYTES - 1);

	localparam logic [MAJOR_W-1:0] MAJOR_RESET = MAJOR_W'(3);

	localparam logic [31:0] AUTH_NONE      = 32'd1;
	localparam logic [31:0] AUTH_CHALLENGE = 32'd2;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_SHORT = 3'd1,
		ST_MAGIC = 3'd2,
		ST_TEXT  = 3'd3,
		ST_MAJOR = 3'd4,
		ST_CONN  = 3'd5
	} status_t;

	typedef struct packed {
		logic       stream_end;
		logic       first_byte;
		logic [7:0] data_byte;
	} in_item_t;

	// Packed so that status lands in the lowest bits of the output tdata.
	typedef struct packed {
		logic [15:0]        frame_height;
		logic [15:0]        frame_width;
		logic [MAJOR_W-1:0] major_version;
		logic               auth_required;
		status_t            status;
	} result_t;

	function automatic logic [7:0] magic_byte(input logic [3:0] idx);
		logic [7:0] ch;
		unique case (idx)
			4'd0:    ch = "v";
			4'd1:    ch = "n";
			4'd2:    ch = "c";
			4'd3:    ch = "L";
			4'd4:    ch = "o";
			4'd5:    ch = "g";
			4'd6:    ch = "0";
			4'd7:    ch = ".";
			4'd8:    ch = "0";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

@@ rtl/core/srhp_in_stage.sv @@
module srhp_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  srhp_pkg::in_item_t in_item,
	input  logic              advance,
	output logic              valid_s1,
	output srhp_pkg::in_item_t item_s1
);
	import srhp_pkg::*;

	// The register frees up in the same cycle its byte moves on to the parser.
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= in_item;
		end
	end

endmodule

@@ rtl/core/srhp_parser.sv @@
module srhp_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  srhp_pkg::in_item_t            item,
	input  logic [srhp_pkg::MAJOR_W-1:0]  required_major,
	output logic                          res_fire,
	output srhp_pkg::result_t             result
);
	import srhp_pkg::*;

	logic [POS_W-1:0]   pos_q, cur_pos, nxt_pos;
	status_t            err_q, cur_err, nxt_err;
	logic [MAJOR_W-1:0] acc_q, cur_acc, nxt_acc;
	logic [31:0]        auth_q, cur_auth, nxt_auth;
	logic               seen_q, cur_seen, nxt_seen;
	logic [15:0]        width_q, cur_width, nxt_width;
	logic [15:0]        height_q, cur_height, nxt_height;
	logic               fin_q, cur_fin, nxt_fin;
	logic [7:0]         b;
	logic [3:0]         k;
	logic               digit;
	logic [POS_W-1:0]   base;
	logic               full;
	status_t            st;

	function automatic status_t keep_first(input status_t cur, input status_t code);
		status_t r;
		r = (cur == ST_OK) ? code : cur;
		return r;
	endfunction

	always_comb begin
		// A first_byte marker clears the parse before this byte is taken.
		cur_pos    = item.first_byte ? '0 : pos_q;
		cur_err    = item.first_byte ? ST_OK : err_q;
		cur_acc    = item.first_byte ? '0 : acc_q;
		cur_auth   = item.first_byte ? '0 : auth_q;
		cur_seen   = item.first_byte ? 1'b0 : seen_q;
		cur_width  = item.first_byte ? '0 : width_q;
		cur_height = item.first_byte ? '0 : height_q;
		cur_fin    = item.first_byte ? 1'b0 : fin_q;

		b     = item.data_byte;
		k     = 4'(cur_pos - MAGIC_END);
		digit = (b >= "0") && (b <= "9");
		base  = cur_seen ? DIMS_SKIP : DIMS_START;

		nxt_pos    = cur_pos;
		nxt_err    = cur_err;
		nxt_acc    = cur_acc;
		nxt_auth   = cur_auth;
		nxt_seen   = cur_seen;
		nxt_width  = cur_width;
		nxt_height = cur_height;
		nxt_fin    = cur_fin;
		full       = 1'b0;
		res_fire   = 1'b0;

		if (!cur_fin) begin
			priority if (cur_pos < MAGIC_END) begin
				if (b != magic_byte(cur_pos[3:0])) begin
					nxt_err = keep_first(cur_err, ST_MAGIC);
				end
			end else if (cur_pos < AUTH_START) begin
				// Version text: "RFB " then three digits, a dot, three digits.
				if ((k >= 4'd4 && k <= 4'd6) || (k >= 4'd8 && k <= 4'd10)) begin
					if (!digit) begin
						nxt_err = keep_first(cur_err, ST_TEXT);
					end else if (k <= 4'd6 && cur_err == ST_OK) begin
						nxt_acc = (cur_acc << 3) + (cur_acc << 1) + MAJOR_W'(b[3:0]);
					end
				end else begin
					priority if (k == 4'd0 && b != "R") nxt_err = keep_first(cur_err, ST_TEXT);
					else if (k == 4'd1 && b != "F") nxt_err = keep_first(cur_err, ST_TEXT);
					else if (k == 4'd2 && b != "B") nxt_err = keep_first(cur_err, ST_TEXT);
					else if (k == 4'd3 && b != " ") nxt_err = keep_first(cur_err, ST_TEXT);
					else if (k == 4'd7 && b != ".") nxt_err = keep_first(cur_err, ST_TEXT);
					else nxt_err = cur_err;
				end
				if (k == 4'd10 && nxt_err == ST_OK && cur_acc != required_major) begin
					nxt_err = ST_MAJOR;
				end
			end else if (cur_pos < DIMS_START) begin
				nxt_auth = {cur_auth[23:0], b};
				if (cur_pos == AUTH_LAST) begin
					if (nxt_auth == AUTH_CHALLENGE) begin
						nxt_seen = 1'b1;
					end else if (nxt_auth != AUTH_NONE) begin
						nxt_err = keep_first(cur_err, ST_CONN);
					end
				end
			end else begin
				if (cur_pos == base || cur_pos == base + POS_W'(1)) begin
					nxt_width = {cur_width[7:0], b};
				end else if (cur_pos == base + POS_W'(2) || cur_pos == base + POS_W'(3)) begin
					nxt_height = {cur_height[7:0], b};
				end
			end

			nxt_pos  = cur_pos + POS_W'(1);
			full     = (cur_pos == HEADER_LAST);
			res_fire = step && (full || item.stream_end);
			nxt_fin  = full || item.stream_end;
		end

		st = full ? nxt_err : ST_SHORT;
		result.status        = st;
		result.auth_required = (st == ST_OK) && nxt_seen;
		result.major_version = (st == ST_OK || st == ST_MAJOR || st == ST_CONN) ? nxt_acc : '0;
		result.frame_width   = (st == ST_OK) ? nxt_width : '0;
		result.frame_height  = (st == ST_OK) ? nxt_height : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			err_q    <= ST_OK;
			acc_q    <= '0;
			auth_q   <= '0;
			seen_q   <= 1'b0;
			width_q  <= '0;
			height_q <= '0;
			fin_q    <= 1'b0;
		end else if (step) begin
			pos_q    <= nxt_pos;
			err_q    <= nxt_err;
			acc_q    <= nxt_acc;
			auth_q   <= nxt_auth;
			seen_q   <= nxt_seen;
			width_q  <= nxt_width;
			height_q <= nxt_height;
			fin_q    <= nxt_fin;
		end
	end

	// After a full header the position rests one past the last header byte.
	a_pos_in_header: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(HEADER_BYTES))
		else $error("byte position ran past the header");

	a_fire_sets_finished: assert property (@(posedge clk) disable iff (!arst_n)
		res_fire |=> fin_q)
		else $error("result given without marking the parse finished");

	a_no_result_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		step && fin_q && !item.first_byte |-> !res_fire)
		else $error("second result for one stream");

	a_error_zeroes_dims: assert property (@(posedge clk) disable iff (!arst_n)
		res_fire && result.status != ST_OK |->
			result.frame_width == '0 && result.frame_height == '0 && !result.auth_required)
		else $error("dimensions reported with an error status");

endmodule

@@ rtl/core/screen_recording_header_parser_top.sv @@
// Header parser for recorded remote-framebuffer streams.
// Input stream: one stream byte per transaction on s_axis. tuser set restarts
// parsing with that byte as byte zero; tlast marks the final byte of a stream.
// Output stream: one result per stream on m_axis, given when header byte 99
// is taken or at an earlier tlast (then reported as a short stream). Bytes
// after the result are ignored until the next tuser byte.
// Configuration: cfg_data is the required major version, written on a
// cfg_valid transaction (cfg_ready is always high). Write it only while idle.
// A result reaches m_axis via the input register, parse stage and output
// register. Throughput: one byte per cycle unless m_axis stalls, set by the
// single parse stage that updates the header state once per byte.
// Reset clears the parse state and the output valid flag, and sets the
// required major version to 3. When the receiver stalls with a result held,
// one more byte is taken into the input register and then s_axis_tready
// drops until the result is taken.
module screen_recording_header_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // first_byte
	input  logic        s_axis_tlast,  // stream_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [2:0] status, [3] auth_required, [13:4] major_version,
	// [29:14] frame_width, [45:30] frame_height, [47:46] zero
	output logic [47:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [9:0]  cfg_data
);
	import srhp_pkg::*;

	in_item_t           in_item, item_s1;
	logic               valid_s1;
	logic               advance;
	logic               res_fire;
	result_t            result, out_q;
	logic               out_valid_q;
	logic [MAJOR_W-1:0] required_major_q;

	assign in_item.data_byte  = s_axis_tdata;
	assign in_item.first_byte = s_axis_tuser;
	assign in_item.stream_end = s_axis_tlast;

	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);

	srhp_in_stage u_in_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.in_item       (in_item),
		.advance       (advance),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1)
	);

	srhp_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.item           (item_s1),
		.required_major (required_major_q),
		.res_fire       (res_fire),
		.result         (result)
	);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			required_major_q <= MAJOR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			required_major_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_q};

endmodule
